[src/pts_pkg.sv]
// shared types, codes and constants for the priority task scheduler
// no dependencies
package pts_pkg;

    localparam int NUM_TASKS_DEF      = 8;
    localparam int NUM_PRIORITIES_DEF = 4;

    localparam logic [3:0] IDLE_ID = 4'd8;
    localparam logic [3:0] NONE_ID = 4'd15;

    localparam logic [2:0] MODE_INIT   = 3'd0;
    localparam logic [2:0] MODE_TICK   = 3'd1;
    localparam logic [2:0] MODE_SWITCH = 3'd2;
    localparam logic [2:0] MODE_DELAY  = 3'd3;
    localparam logic [2:0] MODE_PEND   = 3'd4;

    localparam logic [1:0] TS_READY   = 2'd0;
    localparam logic [1:0] TS_RUNNING = 2'd1;
    localparam logic [1:0] TS_DELAYED = 2'd2;
    localparam logic [1:0] TS_PENDING = 2'd3;

    // per task record, queue position kept as rank inside its queue
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] delay;
        logic        queued;
        logic [2:0]  qidx;
        logic [3:0]  pos;
    } pts_rec_t;

    localparam pts_rec_t REC_RESET = '{
        status: TS_READY, delay: 32'd0, queued: 1'b0, qidx: 3'd0, pos: 4'd0};

    typedef enum logic [2:0] {
        ST_IDLE, ST_FRD, ST_FMOD, ST_PICK, ST_WRD, ST_WMOD, ST_SPRD, ST_DONE
    } pts_state_t;

    typedef enum logic [1:0] {
        WALK_TICK, WALK_DROP, WALK_HEAD
    } pts_walk_t;

endpackage

[src/pts_rec_ram.sv]
// task record memory, registered read, unwritten entries read as reset record
// depends on pts_pkg
module pts_rec_ram #(
    parameter int DEPTH = pts_pkg::NUM_TASKS_DEF,
    parameter int AW    = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [AW-1:0]     rd_addr,
    output pts_pkg::pts_rec_t rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  pts_pkg::pts_rec_t wr_data
);

    pts_pkg::pts_rec_t mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    pts_pkg::pts_rec_t rd_reg;
    logic              rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_reg : pts_pkg::REC_RESET;

endmodule

[src/priority_task_scheduler.sv]
// top level of the priority task scheduler: control sequencer, queue lengths,
// stack pointer memory; depends on pts_pkg and pts_rec_ram
//
// usage
//   s_ channel: one beat per command (init, tick, switch, delay wait,
//   semaphore wait), fields s_mode .. s_sem_free_mask, valid/ready handshake
//   m_ channel: exactly one result beat per command, in order
//   cfg_wr_en / cfg_wr_data write the task priority map, ungated; user writes only while idle
// command sequence
//   one command at a time; the task record memory is walked task by task (read,
//   then modify and write back), which sets the cost of a command
//   init / wait: update the target record, then walk the records to close the
//   gap only when the task sat in a queue; tick: walk every record; switch:
//   requeue the outgoing task, take the head of the highest non-empty queue
//   by a walk, read its stack pointer; errors and unused modes only give a result
// reset
//   aresetn synchronous, active low; all tasks ready, no delays, empty
//   queues, no task running (running code reads 15), tick count zero
// stall
//   the result waits in the output register; the next command is taken
//   meanwhile and holds in its final step until the output register frees
module priority_task_scheduler #(
    parameter int NUM_TASKS      = pts_pkg::NUM_TASKS_DEF,
    parameter int NUM_PRIORITIES = pts_pkg::NUM_PRIORITIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [2:0]  s_task_id,
    input  logic [31:0] s_stack_pointer,
    input  logic [31:0] s_delay_ticks,
    input  logic [7:0]  s_sem_free_mask,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_next_task,
    output logic [31:0] m_next_stack_pointer,
    output logic        m_switched,
    output logic        m_error
);

    // widths that follow from the task and priority counts
    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int SPA_W = $clog2(NUM_TASKS + 1);
    localparam int LEN_W = $clog2(NUM_TASKS + 1);
    localparam int QW    = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;

    // priority of a task from the map, saturated to the top queue
    function automatic logic [2:0] prio_of(input logic [3:0] id, input logic [15:0] map);
        logic [1:0] p;
        p = 2'(map >> {id[2:0], 1'b0});
        if (id >= 4'd8) begin
            p = 2'd0;
        end
        if (32'(p) >= NUM_PRIORITIES) begin
            return 3'(NUM_PRIORITIES - 1);
        end
        return {1'b0, p};
    endfunction

    // control and command registers
    pts_pkg::pts_state_t state_reg, state_next;
    pts_pkg::pts_walk_t  walk_reg, walk_next;
    logic [2:0]        mode_reg, mode_next;
    logic [3:0]        tgt_reg, tgt_next;
    logic [31:0]       dly_reg, dly_next;
    logic [7:0]        mask_reg, mask_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [2:0]        dq_reg, dq_next;
    logic [3:0]        dpos_reg, dpos_next;
    logic [3:0]        chosen_reg, chosen_next;
    logic [3:0]        running_reg, running_next;
    logic [31:0]       tick_reg, tick_next;
    logic [LEN_W-1:0]  len_reg [NUM_PRIORITIES];
    logic [LEN_W-1:0]  len_next [NUM_PRIORITIES];
    logic [15:0]       map_reg;
    logic              err_reg, err_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [3:0]        m_task_reg, m_task_next;
    logic [31:0]       m_sp_reg, m_sp_next;
    logic              m_sw_reg, m_sw_next;
    logic              m_err_reg, m_err_next;

    // record memory port
    logic [IDX_W-1:0]  rec_rd_addr;
    pts_pkg::pts_rec_t rec_rd;
    logic              rec_wr_en;
    logic [IDX_W-1:0]  rec_wr_addr;
    pts_pkg::pts_rec_t rec_wr;

    // saved stack pointers, idle task in the last entry
    logic [31:0]       sp_mem [NUM_TASKS + 1];
    logic [31:0]       sp_rd_reg;
    logic              sp_wr_en;
    logic [SPA_W-1:0]  sp_wr_addr;
    logic [SPA_W-1:0]  sp_rd_addr;

    logic              s_accept;
    logic              out_free;
    logic              run_is_task;
    logic              tid_is_task;
    logic              walk_last;
    logic              pick_found;
    logic [2:0]        pick_q;

    assign s_accept    = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign run_is_task = 32'(running_reg) < NUM_TASKS;
    assign tid_is_task = 32'(s_task_id) < NUM_TASKS;
    assign walk_last   = cnt_reg == IDX_W'(NUM_TASKS - 1);

    // highest non-empty queue
    always_comb begin
        pick_found = 1'b0;
        pick_q     = 3'd0;
        for (int q = 0; q < NUM_PRIORITIES; q++) begin
            if (len_reg[q] != '0) begin
                pick_found = 1'b1;
                pick_q     = 3'(q);
            end
        end
    end

    pts_rec_ram #(
        .DEPTH (NUM_TASKS),
        .AW    (IDX_W)
    ) u_rec_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (rec_rd_addr),
        .rd_data (rec_rd),
        .wr_en   (rec_wr_en),
        .wr_addr (rec_wr_addr),
        .wr_data (rec_wr)
    );

    // stack pointer memory: written when a switch or an init for a real task is taken, read for dispatch
    assign sp_wr_en   = s_accept && ((s_mode == pts_pkg::MODE_INIT && tid_is_task) ||
                                     s_mode == pts_pkg::MODE_SWITCH);
    assign sp_wr_addr = (s_mode == pts_pkg::MODE_INIT) ? SPA_W'(s_task_id) :
                        (run_is_task ? SPA_W'(running_reg) : SPA_W'(NUM_TASKS));
    assign sp_rd_addr = run_is_task ? SPA_W'(running_reg) : SPA_W'(NUM_TASKS);

    always_ff @(posedge aclk) begin
        if (sp_wr_en) begin
            sp_mem[sp_wr_addr] <= s_stack_pointer;
        end
        sp_rd_reg <= sp_mem[sp_rd_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pts_pkg::ST_IDLE: begin
                if (s_accept) begin
                    case (s_mode)
                        pts_pkg::MODE_INIT: begin
                            state_next = tid_is_task ? pts_pkg::ST_FRD : pts_pkg::ST_DONE;
                        end
                        pts_pkg::MODE_TICK: begin
                            state_next = pts_pkg::ST_WRD;
                        end
                        pts_pkg::MODE_SWITCH: begin
                            state_next = run_is_task ? pts_pkg::ST_FRD : pts_pkg::ST_PICK;
                        end
                        pts_pkg::MODE_DELAY, pts_pkg::MODE_PEND: begin
                            state_next = run_is_task ? pts_pkg::ST_FRD : pts_pkg::ST_DONE;
                        end
                        default: begin
                            state_next = pts_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            pts_pkg::ST_FRD: begin
                state_next = pts_pkg::ST_FMOD;
            end
            pts_pkg::ST_FMOD: begin
                if (mode_reg == pts_pkg::MODE_SWITCH) begin
                    state_next = pts_pkg::ST_PICK;
                end else if (rec_rd.queued) begin
                    state_next = pts_pkg::ST_WRD;
                end else begin
                    state_next = pts_pkg::ST_DONE;
                end
            end
            pts_pkg::ST_PICK: begin
                state_next = pick_found ? pts_pkg::ST_WRD : pts_pkg::ST_SPRD;
            end
            pts_pkg::ST_WRD: begin
                state_next = pts_pkg::ST_WMOD;
            end
            pts_pkg::ST_WMOD: begin
                if (walk_last) begin
                    state_next = (walk_reg == pts_pkg::WALK_HEAD) ? pts_pkg::ST_SPRD
                                                                  : pts_pkg::ST_DONE;
                end else begin
                    state_next = pts_pkg::ST_WRD;
                end
            end
            pts_pkg::ST_SPRD: begin
                state_next = pts_pkg::ST_DONE;
            end
            pts_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = pts_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pts_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        pts_pkg::pts_rec_t r;
        logic [2:0]        nq;

        r            = rec_rd;
        nq           = 3'd0;
        walk_next    = walk_reg;
        mode_next    = mode_reg;
        tgt_next     = tgt_reg;
        dly_next     = dly_reg;
        mask_next    = mask_reg;
        cnt_next     = cnt_reg;
        dq_next      = dq_reg;
        dpos_next    = dpos_reg;
        chosen_next  = chosen_reg;
        running_next = running_reg;
        tick_next    = tick_reg;
        err_next     = err_reg;
        len_next     = len_reg;
        rec_rd_addr  = cnt_reg;
        rec_wr_en    = 1'b0;
        rec_wr_addr  = cnt_reg;
        rec_wr       = rec_rd;
        m_valid_next = m_valid_reg && !m_ready;
        m_task_next  = m_task_reg;
        m_sp_next    = m_sp_reg;
        m_sw_next    = m_sw_reg;
        m_err_next   = m_err_reg;
        s_ready      = state_reg == pts_pkg::ST_IDLE;

        case (state_reg)
            pts_pkg::ST_IDLE: begin
                if (s_accept) begin
                    mode_next = s_mode;
                    tgt_next  = (s_mode == pts_pkg::MODE_INIT) ? {1'b0, s_task_id}
                                                               : running_reg;
                    dly_next  = s_delay_ticks;
                    mask_next = s_sem_free_mask;
                    cnt_next  = '0;
                    err_next  = 1'b0;
                    if (s_mode == pts_pkg::MODE_TICK) begin
                        tick_next = tick_reg + 32'd1;
                        walk_next = pts_pkg::WALK_TICK;
                    end
                    if ((s_mode == pts_pkg::MODE_DELAY ||
                         s_mode == pts_pkg::MODE_PEND) && !run_is_task) begin
                        err_next = 1'b1;
                    end
                end
            end
            pts_pkg::ST_FRD: begin
                rec_rd_addr = IDX_W'(tgt_reg);
            end
            pts_pkg::ST_FMOD: begin
                // single entry update of the target task
                rec_wr_addr = IDX_W'(tgt_reg);
                dq_next     = rec_rd.qidx;
                dpos_next   = rec_rd.pos;
                walk_next   = pts_pkg::WALK_DROP;
                cnt_next    = '0;
                case (mode_reg)
                    pts_pkg::MODE_INIT: begin
                        if (rec_rd.queued) begin
                            len_next[rec_rd.qidx[QW-1:0]] =
                                len_next[rec_rd.qidx[QW-1:0]] - LEN_W'(1);
                        end
                        nq       = prio_of(tgt_reg, map_reg);
                        r.status = pts_pkg::TS_READY;
                        r.queued = 1'b1;
                        r.qidx   = nq;
                        r.pos    = 4'(len_next[nq[QW-1:0]]);
                        len_next[nq[QW-1:0]] = len_next[nq[QW-1:0]] + LEN_W'(1);
                        rec_wr_en = 1'b1;
                        rec_wr    = r;
                    end
                    pts_pkg::MODE_DELAY, pts_pkg::MODE_PEND: begin
                        if (rec_rd.queued) begin
                            len_next[rec_rd.qidx[QW-1:0]] =
                                len_next[rec_rd.qidx[QW-1:0]] - LEN_W'(1);
                        end
                        if (mode_reg == pts_pkg::MODE_DELAY) begin
                            r.status = pts_pkg::TS_DELAYED;
                            r.delay  = dly_reg;
                        end else begin
                            r.status = pts_pkg::TS_PENDING;
                        end
                        r.queued  = 1'b0;
                        rec_wr_en = 1'b1;
                        rec_wr    = r;
                    end
                    pts_pkg::MODE_SWITCH: begin
                        // outgoing task still running goes to the back of its queue
                        if (rec_rd.status == pts_pkg::TS_RUNNING) begin
                            nq       = prio_of(tgt_reg, map_reg);
                            r.status = pts_pkg::TS_READY;
                            r.queued = 1'b1;
                            r.qidx   = nq;
                            r.pos    = 4'(len_reg[nq[QW-1:0]]);
                            len_next[nq[QW-1:0]] = len_reg[nq[QW-1:0]] + LEN_W'(1);
                            rec_wr_en = 1'b1;
                            rec_wr    = r;
                        end
                    end
                    default: begin
                        rec_wr_en = 1'b0;
                    end
                endcase
            end
            pts_pkg::ST_PICK: begin
                if (pick_found) begin
                    len_next[pick_q[QW-1:0]] = len_reg[pick_q[QW-1:0]] - LEN_W'(1);
                    dq_next   = pick_q;
                    walk_next = pts_pkg::WALK_HEAD;
                    cnt_next  = '0;
                end else begin
                    running_next = pts_pkg::IDLE_ID;
                end
            end
            pts_pkg::ST_WMOD: begin
                rec_wr_en = 1'b1;
                cnt_next  = cnt_reg + IDX_W'(1);
                case (walk_reg)
                    pts_pkg::WALK_TICK: begin
                        if (rec_rd.status == pts_pkg::TS_DELAYED && rec_rd.delay != '0) begin
                            r.delay = rec_rd.delay - 32'd1;
                            if (rec_rd.delay == 32'd1) begin
                                nq       = prio_of(4'(cnt_reg), map_reg);
                                r.status = pts_pkg::TS_READY;
                                r.queued = 1'b1;
                                r.qidx   = nq;
                                r.pos    = 4'(len_reg[nq[QW-1:0]]);
                                len_next[nq[QW-1:0]] = len_reg[nq[QW-1:0]] + LEN_W'(1);
                            end
                        end else if (rec_rd.status == pts_pkg::TS_PENDING &&
                                     4'(cnt_reg) < 4'd8 &&
                                     mask_reg[3'(cnt_reg)]) begin
                            nq       = prio_of(4'(cnt_reg), map_reg);
                            r.status = pts_pkg::TS_READY;
                            r.queued = 1'b1;
                            r.qidx   = nq;
                            r.pos    = 4'(len_reg[nq[QW-1:0]]);
                            len_next[nq[QW-1:0]] = len_reg[nq[QW-1:0]] + LEN_W'(1);
                        end
                    end
                    pts_pkg::WALK_DROP: begin
                        // close the gap behind the removed entry
                        if (4'(cnt_reg) == tgt_reg) begin
                            rec_wr_en = 1'b0;
                        end else if (rec_rd.queued && rec_rd.qidx == dq_reg &&
                                     rec_rd.pos > dpos_reg) begin
                            r.pos = rec_rd.pos - 4'd1;
                        end
                    end
                    pts_pkg::WALK_HEAD: begin
                        if (rec_rd.queued && rec_rd.qidx == dq_reg) begin
                            if (rec_rd.pos == 4'd0) begin
                                r.queued    = 1'b0;
                                r.status    = pts_pkg::TS_RUNNING;
                                chosen_next = 4'(cnt_reg);
                            end else begin
                                r.pos = rec_rd.pos - 4'd1;
                            end
                        end
                        if (walk_last) begin
                            running_next = chosen_next;
                        end
                    end
                    default: begin
                        rec_wr_en = 1'b0;
                    end
                endcase
                rec_wr = r;
            end
            pts_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_task_next  = running_reg;
                    m_sw_next    = mode_reg == pts_pkg::MODE_SWITCH;
                    m_sp_next    = (mode_reg == pts_pkg::MODE_SWITCH) ? sp_rd_reg : 32'd0;
                    m_err_next   = err_reg;
                end
            end
            default: begin
                rec_wr_en = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pts_pkg::ST_IDLE;
            running_reg <= pts_pkg::NONE_ID;
            tick_reg    <= '0;
            map_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int q = 0; q < NUM_PRIORITIES; q++) begin
                len_reg[q] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            running_reg <= running_next;
            tick_reg    <= tick_next;
            m_valid_reg <= m_valid_next;
            len_reg     <= len_next;
            if (cfg_wr_en) begin
                map_reg <= cfg_wr_data;
            end
        end
    end

    // command and result payload
    always_ff @(posedge aclk) begin
        walk_reg   <= walk_next;
        mode_reg   <= mode_next;
        tgt_reg    <= tgt_next;
        dly_reg    <= dly_next;
        mask_reg   <= mask_next;
        cnt_reg    <= cnt_next;
        dq_reg     <= dq_next;
        dpos_reg   <= dpos_next;
        chosen_reg <= chosen_next;
        err_reg    <= err_next;
        m_task_reg <= m_task_next;
        m_sp_reg   <= m_sp_next;
        m_sw_reg   <= m_sw_next;
        m_err_reg  <= m_err_next;
    end

    assign m_valid              = m_valid_reg;
    assign m_next_task          = m_task_reg;
    assign m_next_stack_pointer = m_sp_reg;
    assign m_switched           = m_sw_reg;
    assign m_error              = m_err_reg;

    // running task is a real task, the idle task or none
    assert property (@(posedge aclk) disable iff (!aresetn)
        run_is_task || running_reg == pts_pkg::IDLE_ID || running_reg == pts_pkg::NONE_ID)
        else $error("running task code out of range");

    // after any switch some task or idle runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_switched |-> m_next_task != pts_pkg::NONE_ID)
        else $error("switch result without a dispatched task");

    // error and switch never come together
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error |-> !m_switched)
        else $error("error flagged on a switch beat");

    // the sequencer leaves idle once a command is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg != pts_pkg::ST_IDLE)
        else $error("sequencer did not leave idle after a command");

endmodule
